// File: rtl/trapmp_pkg.sv
package trapmp_pkg;

   // fixed field widths
   localparam int QW   = 32;
   localparam int WW   = 34;
   localparam int PW   = 64;
   localparam int CSRW = 8;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [WW-1:0] w_type;
   typedef logic signed [PW-1:0] p_type;

   localparam q_type Q_MAX = 32'sh7fffffff;
   localparam q_type Q_MIN = 32'sh80000000;
   localparam p_type P_QMAX = 64'sd2147483647;
   localparam p_type P_QMIN = -64'sd2147483648;

   // register indexes
   localparam logic [CSRW-1:0] CSR_DISTANCE = 8'd0;
   localparam logic [CSRW-1:0] CSR_ACCEL    = 8'd1;
   localparam logic [CSRW-1:0] CSR_VELOCITY = 8'd2;
   localparam logic [CSRW-1:0] CSR_DECEL    = 8'd3;

   // segment of the move an item falls in
   typedef enum logic [2:0] {
      R_LINEAR,
      R_INVALID,
      R_RAMP,
      R_CRUISE,
      R_CLAMP,
      R_DECEL
   } region_type;

   // profile sequencer states
   typedef enum logic [4:0] {
      P_IDLE,
      P_LIN,
      P_LIN_W,
      P_ACC,
      P_ACC_W,
      P_ACC_MUL,
      P_ACC_D,
      P_DEC,
      P_DEC_W,
      P_DEC_MUL,
      P_DEC_D,
      P_SUM,
      P_SCA_MUL,
      P_SCA,
      P_SCA_W,
      P_SQA_DIV,
      P_SQA_DW,
      P_SQA,
      P_SQA_W,
      P_SCD_MUL,
      P_SCD,
      P_SCD_W,
      P_SQD_DIV,
      P_SQD_DW,
      P_SQD,
      P_SQD_W,
      P_CRU,
      P_CRU_W,
      P_END
   } prof_state_type;

   // move profile derived from the registers
   typedef struct packed {
      logic  linear;
      logic  ramp_ok;
      q_type a;
      q_type r;
      q_type v;
      q_type d;
      q_type acc_t;
      q_type acc_d;
      w_type t1;
      w_type t_end;
      q_type tend_sat;
      q_type lin_tend;
   } prof_type;

   // divide request
   typedef struct packed {
      logic  start;
      logic  shift;
      p_type num;
      w_type den;
   } div_req_type;

   // saturate to the signed 32-bit range
   function automatic q_type sat32(input p_type v);
      q_type res;
      if (v > P_QMAX) begin
         res = Q_MAX;
      end else if (v < P_QMIN) begin
         res = Q_MIN;
      end else begin
         res = v[QW-1:0];
      end
      return res;
   endfunction

   // product scaled down toward zero, then saturated
   function automatic q_type mulq(input p_type p, input int unsigned sh);
      logic [PW-1:0] m;
      p_type s;
      m = p[PW-1] ? PW'(-p) : PW'(p);
      m = m >> sh;
      s = p[PW-1] ? -$signed(m) : $signed(m);
      return sat32(s);
   endfunction

endpackage

// File: rtl/trapezoidal_motion_position.sv
// Position on a trapezoidal move (accelerate, cruise, decelerate) for a given elapsed
// time, all values signed fixed point with FRACTION_BITS fraction bits. Every register
// write starts a recompute of the move profile (ramp times and distances, ramp scaling
// for short moves, end time) on one shared bit-serial divider and one square-root unit,
// using up to eight divides and two roots, and no request is taken until it finishes.
// After that one request enters per cycle while the output is not held by rsp_ready;
// each passes through stage 1, stage 2, stage 3 and the output register. The two
// chained multiplies of the ramp segments set the pipeline depth.
module trapezoidal_motion_position #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  trapmp_pkg::q_type           req_elapsed_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output trapmp_pkg::q_type           rsp_position,
   output trapmp_pkg::q_type           rsp_time_out,
   output logic                        rsp_time_clamped,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [trapmp_pkg::CSRW-1:0] csr_index,
   input  trapmp_pkg::q_type           csr_data
);
   import trapmp_pkg::*;

   prof_type prof;
   logic     prof_idle;

   // register file and profile sequencer
   trapmp_profile #(.FRACTION_BITS(FRACTION_BITS)) u_profile (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .prof      (prof),
      .idle      (prof_idle)
   );

   // per-request evaluation pipeline
   trapmp_eval #(.FRACTION_BITS(FRACTION_BITS)) u_eval (
      .clock            (clock),
      .reset            (reset),
      .prof             (prof),
      .prof_idle        (prof_idle),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_elapsed_time (req_elapsed_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_time_out     (rsp_time_out),
      .rsp_time_clamped (rsp_time_clamped)
   );

endmodule

// File: rtl/trapmp_div.sv
module trapmp_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  trapmp_pkg::div_req_type  req,
   output logic                     done,
   output trapmp_pkg::p_type        quo
);
   import trapmp_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [PW-1:0]     dd_ff;
   logic [WW-1:0]     ds_ff;
   logic [WW-1:0]     rem_ff;
   logic [5:0]        cnt_ff;

   logic [PW-1:0]     mag;
   logic [WW:0]       rem_sh;
   logic              ge;

   // magnitude of the dividend, pre-scaled when asked
   always_comb begin
      mag = req.num[PW-1] ? PW'(-req.num) : PW'(req.num);
      if (req.shift) begin
         mag = mag << FRACTION_BITS;
      end
   end

   // one quotient bit per cycle
   assign rem_sh = {rem_ff, dd_ff[PW-1]};
   assign ge     = rem_sh >= {1'b0, ds_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            if (req.den == '0) begin
               // divide by zero: saturate by the sign of the dividend
               dd_ff   <= (req.num != '0) ? (PW'(1) << (PW - 2)) : '0;
               neg_ff  <= req.num[PW-1];
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               dd_ff   <= mag;
               ds_ff   <= req.den[WW-1] ? WW'(-req.den) : WW'(req.den);
               rem_ff  <= '0;
               neg_ff  <= req.num[PW-1] ^ req.den[WW-1];
               cnt_ff  <= 6'd63;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= ge ? WW'(rem_sh - {1'b0, ds_ff}) : rem_sh[WW-1:0];
            dd_ff  <= {dd_ff[PW-2:0], ge};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed(dd_ff) : $signed(dd_ff);

endmodule

// File: rtl/trapmp_sqrt.sv
module trapmp_sqrt #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  trapmp_pkg::q_type  x,
   output logic               done,
   output trapmp_pkg::q_type  root
);
   import trapmp_pkg::*;

   logic          busy_ff;
   logic          done_ff;
   logic [PW-1:0] v_ff;
   logic [PW-1:0] r_ff;
   logic [4:0]    cnt_ff;

   logic [PW-1:0] bit_w;
   logic [PW-1:0] rb;

   // two result bits of weight per step, from the top down
   assign bit_w = PW'(1) << {cnt_ff, 1'b0};
   assign rb    = r_ff + bit_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            v_ff    <= (x > 0) ? ({32'b0, x} << FRACTION_BITS) : '0;
            r_ff    <= '0;
            cnt_ff  <= 5'd31;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (v_ff >= rb) begin
               v_ff <= v_ff - rb;
               r_ff <= (r_ff >> 1) + bit_w;
            end else begin
               r_ff <= r_ff >> 1;
            end
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = (r_ff[PW-1:QW-1] != '0) ? Q_MAX : $signed(r_ff[QW-1:0]);

endmodule

// File: rtl/trapmp_profile.sv
module trapmp_profile #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [trapmp_pkg::CSRW-1:0] csr_index,
   input  trapmp_pkg::q_type           csr_data,
   output trapmp_pkg::prof_type        prof,
   output logic                        idle
);
   import trapmp_pkg::*;

   prof_state_type state_ff, state_in;

   q_type d_ff, a_ff, v_ff, r_ff;
   q_type acc_t_ff, acc_d_ff, dec_t_ff, dec_d_ff;
   q_type lin_tend_ff, tend_sat_ff;
   w_type sum_ff, t1_ff, t_end_ff;
   p_type prod_ff;

   div_req_type div_req;
   logic        div_done;
   p_type       div_quo;
   logic        sqrt_start;
   q_type       sqrt_x;
   logic        sqrt_done;
   q_type       sqrt_root;
   q_type       mul_a, mul_b;
   w_type       sum_w;
   logic        csr_wr;

   trapmp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   trapmp_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .x     (sqrt_x),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign csr_ready = (state_ff == P_IDLE);
   assign csr_wr    = csr_valid && csr_ready;
   assign sum_w     = w_type'(acc_d_ff) + w_type'(dec_d_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         P_IDLE:    if (csr_wr) state_in = P_LIN;
         P_LIN:     state_in = P_LIN_W;
         P_LIN_W:   if (div_done) state_in = P_ACC;
         P_ACC:     state_in = (a_ff > 0) ? P_ACC_W : P_ACC_MUL;
         P_ACC_W:   if (div_done) state_in = P_ACC_MUL;
         P_ACC_MUL: state_in = P_ACC_D;
         P_ACC_D:   state_in = P_DEC;
         P_DEC:     state_in = (r_ff > 0) ? P_DEC_W : P_DEC_MUL;
         P_DEC_W:   if (div_done) state_in = P_DEC_MUL;
         P_DEC_MUL: state_in = P_DEC_D;
         P_DEC_D:   state_in = P_SUM;
         P_SUM: begin
            priority if (sum_w <= w_type'(d_ff)) state_in = P_CRU;
            else if (a_ff > 0)                   state_in = P_SCA_MUL;
            else if (r_ff > 0)                   state_in = P_SCD_MUL;
            else                                 state_in = P_CRU;
         end
         P_SCA_MUL: state_in = P_SCA;
         P_SCA:     state_in = P_SCA_W;
         P_SCA_W:   if (div_done) state_in = P_SQA_DIV;
         P_SQA_DIV: state_in = P_SQA_DW;
         P_SQA_DW:  if (div_done) state_in = P_SQA;
         P_SQA:     state_in = P_SQA_W;
         P_SQA_W:   if (sqrt_done) state_in = (r_ff > 0) ? P_SCD_MUL : P_CRU;
         P_SCD_MUL: state_in = P_SCD;
         P_SCD:     state_in = P_SCD_W;
         P_SCD_W:   if (div_done) state_in = P_SQD_DIV;
         P_SQD_DIV: state_in = P_SQD_DW;
         P_SQD_DW:  if (div_done) state_in = P_SQD;
         P_SQD:     state_in = P_SQD_W;
         P_SQD_W:   if (sqrt_done) state_in = P_CRU;
         P_CRU:     state_in = P_CRU_W;
         P_CRU_W:   if (div_done) state_in = P_END;
         P_END:     state_in = P_IDLE;
         default:   state_in = P_IDLE;
      endcase
   end

   // divider, root and multiplier operands
   always_comb begin
      div_req.start = 1'b0;
      div_req.shift = 1'b1;
      div_req.num   = '0;
      div_req.den   = '0;
      sqrt_start    = 1'b0;
      sqrt_x        = acc_t_ff;
      mul_a         = v_ff;
      mul_b         = acc_t_ff;
      unique case (state_ff)
         P_LIN: begin
            div_req.start = 1'b1;
            div_req.num   = p_type'(d_ff);
            div_req.den   = w_type'(v_ff);
         end
         P_ACC: begin
            div_req.start = (a_ff > 0);
            div_req.num   = p_type'(v_ff);
            div_req.den   = w_type'(a_ff);
         end
         P_DEC: begin
            div_req.start = (r_ff > 0);
            div_req.num   = p_type'(v_ff);
            div_req.den   = w_type'(r_ff);
         end
         P_DEC_MUL: mul_b = dec_t_ff;
         P_SCA_MUL: begin
            mul_a = acc_d_ff;
            mul_b = d_ff;
         end
         P_SCD_MUL: begin
            mul_a = dec_d_ff;
            mul_b = d_ff;
         end
         P_SCA, P_SCD: begin
            div_req.start = 1'b1;
            div_req.shift = 1'b0;
            div_req.num   = prod_ff;
            div_req.den   = sum_ff;
         end
         P_SQA_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = p_type'(acc_d_ff) <<< 1;
            div_req.den   = w_type'(a_ff);
         end
         P_SQD_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = p_type'(dec_d_ff) <<< 1;
            div_req.den   = w_type'(r_ff);
         end
         P_SQA: sqrt_start = 1'b1;
         P_SQD: begin
            sqrt_start = 1'b1;
            sqrt_x     = dec_t_ff;
         end
         P_CRU: begin
            div_req.start = 1'b1;
            div_req.num   = p_type'(d_ff) - p_type'(acc_d_ff) - p_type'(dec_d_ff);
            div_req.den   = w_type'(v_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // register file and profile results
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff        <= '0;
         a_ff        <= '0;
         v_ff        <= '0;
         r_ff        <= '0;
         lin_tend_ff <= '0;
      end else begin
         if (csr_wr) begin
            if (csr_index == CSR_DISTANCE) d_ff <= csr_data;
            if (csr_index == CSR_ACCEL)    a_ff <= csr_data;
            if (csr_index == CSR_VELOCITY) v_ff <= csr_data;
            if (csr_index == CSR_DECEL)    r_ff <= csr_data;
         end
         unique case (state_ff)
            P_LIN_W:   if (div_done) lin_tend_ff <= sat32(div_quo);
            P_ACC: begin
               acc_t_ff <= '0;
               dec_d_ff <= '0;
            end
            P_ACC_W:   if (div_done) acc_t_ff <= sat32(div_quo);
            P_ACC_MUL, P_DEC_MUL, P_SCA_MUL, P_SCD_MUL: prod_ff <= mul_a * mul_b;
            P_ACC_D:   acc_d_ff <= mulq(prod_ff, FRACTION_BITS + 1);
            P_DEC:     dec_t_ff <= '0;
            P_DEC_W:   if (div_done) dec_t_ff <= sat32(div_quo);
            P_DEC_D:   dec_d_ff <= mulq(prod_ff, FRACTION_BITS + 1);
            P_SUM:     sum_ff <= sum_w;
            P_SCA_W:   if (div_done) acc_d_ff <= div_quo[QW-1:0];
            P_SQA_DW:  if (div_done) acc_t_ff <= sat32(div_quo);
            P_SQA_W:   if (sqrt_done) acc_t_ff <= sqrt_root;
            P_SCD_W:   if (div_done) dec_d_ff <= div_quo[QW-1:0];
            P_SQD_DW:  if (div_done) dec_t_ff <= sat32(div_quo);
            P_SQD_W:   if (sqrt_done) dec_t_ff <= sqrt_root;
            P_CRU_W:   if (div_done) t1_ff <= w_type'(acc_t_ff) + w_type'(sat32(div_quo));
            P_END: begin
               t_end_ff    <= t1_ff + w_type'(dec_t_ff);
               tend_sat_ff <= sat32(p_type'(t1_ff) + p_type'(dec_t_ff));
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prof.linear   = (a_ff <= 0) && (r_ff <= 0);
      prof.ramp_ok  = (v_ff > 0) && (d_ff > 0);
      prof.a        = a_ff;
      prof.r        = r_ff;
      prof.v        = v_ff;
      prof.d        = d_ff;
      prof.acc_t    = acc_t_ff;
      prof.acc_d    = acc_d_ff;
      prof.t1       = t1_ff;
      prof.t_end    = t_end_ff;
      prof.tend_sat = tend_sat_ff;
      prof.lin_tend = lin_tend_ff;
   end

   assign idle = (state_ff == P_IDLE);

endmodule

// File: rtl/trapmp_eval.sv
module trapmp_eval #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  trapmp_pkg::prof_type  prof,
   input  logic                  prof_idle,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  trapmp_pkg::q_type     req_elapsed_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output trapmp_pkg::q_type     rsp_position,
   output trapmp_pkg::q_type     rsp_time_out,
   output logic                  rsp_time_clamped
);
   import trapmp_pkg::*;

   logic en;

   // stage 1: segment decode and operand select
   logic       s1_valid_ff;
   region_type s1_region_ff, s1_region_in;
   q_type      s1_t_ff, s1_x_ff, s1_x_in, s1_aop_ff, s1_aop_in, s1_y_ff, s1_y_in;
   w_type      t_w;

   // stage 2: raw products
   logic       s2_valid_ff;
   region_type s2_region_ff;
   q_type      s2_t_ff, s2_x_ff;
   p_type      s2_p1_ff, s2_p2_ff;

   // stage 3: second product
   logic       s3_valid_ff;
   region_type s3_region_ff;
   q_type      s3_t_ff, s3_m2_ff;
   p_type      s3_p3_ff;
   q_type      q1;

   // output stage
   logic       out_valid_ff;
   q_type      pos_ff, pos_in, tout_ff, tout_in;
   logic       clamp_ff, clamp_in;
   q_type      q3;

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en && prof_idle;
   assign t_w       = w_type'(req_elapsed_time);

   always_comb begin
      s1_region_in = R_INVALID;
      s1_x_in      = '0;
      s1_aop_in    = '0;
      s1_y_in      = '0;
      priority if (prof.linear) begin
         s1_region_in = R_LINEAR;
         s1_y_in      = req_elapsed_time;
      end else if (req_elapsed_time > 0 && prof.ramp_ok) begin
         priority if (t_w <= w_type'(prof.acc_t)) begin
            s1_region_in = R_RAMP;
            s1_x_in      = req_elapsed_time;
            s1_aop_in    = prof.a;
         end else if (t_w <= prof.t1) begin
            s1_region_in = R_CRUISE;
            s1_y_in      = sat32(p_type'(req_elapsed_time) - p_type'(prof.acc_t));
         end else if (t_w >= prof.t_end) begin
            s1_region_in = R_CLAMP;
         end else begin
            s1_region_in = R_DECEL;
            s1_x_in      = sat32(p_type'(prof.t_end) - p_type'(req_elapsed_time));
            s1_aop_in    = prof.r;
         end
      end else begin
         s1_region_in = R_INVALID;
      end
   end

   assign q1 = mulq(s2_p1_ff, FRACTION_BITS);
   assign q3 = mulq(s3_p3_ff, FRACTION_BITS + 1);

   // final selection per segment
   always_comb begin
      pos_in   = '0;
      tout_in  = s3_t_ff;
      clamp_in = 1'b0;
      unique case (s3_region_ff)
         R_LINEAR: begin
            if (s3_m2_ff > prof.d) begin
               pos_in   = prof.d;
               tout_in  = prof.lin_tend;
               clamp_in = 1'b1;
            end else begin
               pos_in = (s3_m2_ff > 0) ? s3_m2_ff : '0;
            end
         end
         R_INVALID: pos_in = '0;
         R_RAMP:    pos_in = q3;
         R_CRUISE:  pos_in = sat32(p_type'(prof.acc_d) + p_type'(s3_m2_ff));
         R_CLAMP: begin
            pos_in   = prof.d;
            tout_in  = prof.tend_sat;
            clamp_in = 1'b1;
         end
         R_DECEL:   pos_in = sat32(p_type'(prof.d) - p_type'(q3));
         default:   pos_in = '0;
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_valid && req_ready;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_region_ff <= s1_region_in;
         s1_t_ff      <= req_elapsed_time;
         s1_x_ff      <= s1_x_in;
         s1_aop_ff    <= s1_aop_in;
         s1_y_ff      <= s1_y_in;

         s2_region_ff <= s1_region_ff;
         s2_t_ff      <= s1_t_ff;
         s2_x_ff      <= s1_x_ff;
         s2_p1_ff     <= s1_aop_ff * s1_x_ff;
         s2_p2_ff     <= prof.v * s1_y_ff;

         s3_region_ff <= s2_region_ff;
         s3_t_ff      <= s2_t_ff;
         s3_p3_ff     <= q1 * s2_x_ff;
         s3_m2_ff     <= mulq(s2_p2_ff, FRACTION_BITS);

         pos_ff       <= pos_in;
         tout_ff      <= tout_in;
         clamp_ff     <= clamp_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_position     = pos_ff;
   assign rsp_time_out     = tout_ff;
   assign rsp_time_clamped = clamp_ff;

endmodule

// File: tb/sv/trapezoidal_motion_position_tb.sv
module trapezoidal_motion_position_tb;
   import trapmp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit           is_csr;
      logic [CSRW-1:0] index;
      q_type        value;
   } stim_type;

   typedef struct {
      longint d;
      longint a;
      longint v;
      longint r;
   } move_type;

   typedef struct {
      q_type pos;
      q_type tout;
      logic  clamped;
   } point_type;

   localparam int FB = 16;
   localparam longint QMAX64 = 64'sd2147483647;
   localparam longint QMIN64 = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSRW-1:0] csr_index = '0;
   q_type req_elapsed_time = '0;
   q_type csr_data = '0;
   logic req_ready, rsp_valid, rsp_time_clamped, csr_ready;
   q_type rsp_position, rsp_time_out;

   stim_type  pending_stim[$];
   point_type expected_points[$];
   move_type  live_move = '{0, 0, 0, 0};
   move_type  gen_move = '{0, 0, 0, 0};
   int        requests_sent = 0;
   int        responses_seen = 0;
   int        quiet_cycles = 0;
   int        hold_cycles = 0;
   bit        hold_done = 0;
   int        errors = 0;

   trapezoidal_motion_position dut (.*);

   // clock and reset
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic longint clip_q(longint x);
      if (x > QMAX64) return QMAX64;
      if (x < QMIN64) return QMIN64;
      return x;
   endfunction

   // product scaled toward zero
   function automatic longint fx_mul(longint x, longint y, int sh);
      longint p;
      longint unsigned m;
      p = x * y;
      m = (p < 0) ? longint'(-p) : p;
      m = m >> sh;
      return clip_q((p < 0) ? -longint'(m) : longint'(m));
   endfunction

   function automatic longint fx_div(longint n, longint dv);
      if (dv == 0) return (n > 0) ? QMAX64 : ((n < 0) ? QMIN64 : 0);
      return clip_q((n * (64'sd1 << FB)) / dv);
   endfunction

   function automatic longint fx_sqrt(longint x);
      longint unsigned w, root, b;
      if (x <= 0) return 0;
      w = longint'(x) << FB;
      root = 0;
      b = 64'd1 << 62;
      while (b > w) b = b >> 2;
      while (b != 0) begin
         if (w >= root + b) begin
            w = w - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return clip_q(longint'(root));
   endfunction

   // position on the move at time t
   function automatic point_type move_position(move_type mv, q_type t_in);
      point_type res;
      longint t, pos, tout, lin_dist, acc_t, acc_d, dec_t, dec_d, sum, cru, t1, t_end, dt;
      logic clamped;
      t = t_in;
      pos = 0;
      tout = t;
      clamped = 0;
      if (mv.a <= 0 && mv.r <= 0) begin
         lin_dist = fx_mul(mv.v, t, FB);
         if (lin_dist > mv.d) begin
            pos = mv.d;
            tout = fx_div(mv.d, mv.v);
            clamped = 1;
         end else begin
            pos = (lin_dist > 0) ? lin_dist : 0;
         end
      end else if (t > 0 && mv.v > 0 && mv.d > 0) begin
         acc_t = (mv.a > 0) ? fx_div(mv.v, mv.a) : 0;
         acc_d = fx_mul(mv.v, acc_t, FB + 1);
         dec_t = (mv.r > 0) ? fx_div(mv.v, mv.r) : 0;
         dec_d = fx_mul(mv.v, dec_t, FB + 1);
         sum = acc_d + dec_d;
         // short move: shrink both ramps
         if (sum > mv.d) begin
            if (mv.a > 0) begin
               acc_d = (acc_d * mv.d) / sum;
               acc_t = fx_sqrt(fx_div(2 * acc_d, mv.a));
            end
            if (mv.r > 0) begin
               dec_d = (dec_d * mv.d) / sum;
               dec_t = fx_sqrt(fx_div(2 * dec_d, mv.r));
            end
            sum = acc_d + dec_d;
         end
         if (t <= acc_t) begin
            pos = fx_mul(fx_mul(mv.a, t, FB), t, FB + 1);
         end else begin
            cru = fx_div(mv.d - sum, mv.v);
            t1 = acc_t + cru;
            t_end = t1 + dec_t;
            if (t <= t1) begin
               pos = clip_q(acc_d + fx_mul(clip_q(t - acc_t), mv.v, FB));
            end else if (t >= t_end) begin
               pos = mv.d;
               tout = clip_q(t_end);
               clamped = 1;
            end else begin
               dt = clip_q(t_end - t);
               pos = clip_q(mv.d - fx_mul(fx_mul(mv.r, dt, FB), dt, FB + 1));
            end
         end
      end
      res.pos = q_type'(pos);
      res.tout = q_type'(tout);
      res.clamped = clamped;
      return res;
   endfunction

   function automatic int sender_idle_pct();
      if (requests_sent < 520) return 38;
      if (requests_sent < 1040) return 74;
      return 0;
   endfunction

   // request and register driver
   always @(posedge clock) begin : driver
      logic nv_req, nv_csr;
      stim_type head;
      nv_req = req_valid;
      nv_csr = csr_valid;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_points.push_back(move_position(live_move, req_elapsed_time));
            void'(pending_stim.pop_front());
            requests_sent++;
            nv_req = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DISTANCE: live_move.d = csr_data;
               CSR_ACCEL:    live_move.a = csr_data;
               CSR_VELOCITY: live_move.v = csr_data;
               CSR_DECEL:    live_move.r = csr_data;
               default: ;
            endcase
            void'(pending_stim.pop_front());
            nv_csr = 1'b0;
         end
         if (!nv_req && !nv_csr && pending_stim.size() != 0) begin
            head = pending_stim[0];
            if (head.is_csr) begin
               // registers change only once the block has drained
               if (expected_points.size() == 0 && quiet_cycles >= 12) begin
                  nv_csr = 1'b1;
                  csr_index <= head.index;
                  csr_data <= head.value;
               end
            end else if ($urandom_range(99) >= sender_idle_pct()) begin
               nv_req = 1'b1;
               req_elapsed_time <= head.value;
            end
         end
      end
      req_valid <= nv_req;
      csr_valid <= nv_csr;
   end

   // long receiver hold-off to back up the pipeline
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && responses_seen >= 300) begin
         hold_cycles <= 250;
         hold_done <= 1;
      end
   end

   // response checker
   always @(posedge clock) begin : monitor
      point_type want;
      int pct;
      pct = (requests_sent < 520) ? 74 : ((requests_sent < 1040) ? 38 : 0);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_points.size() == 0) begin
               $error("response with no request outstanding: position %0d", rsp_position);
               errors++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_position !== want.pos) begin
                  $error("position: expected %0d, got %0d", want.pos, rsp_position);
                  errors++;
               end
               if (rsp_time_out !== want.tout) begin
                  $error("time_out: expected %0d, got %0d", want.tout, rsp_time_out);
                  errors++;
               end
               if (rsp_time_clamped !== want.clamped) begin
                  $error("time_clamped: expected %0b, got %0b", want.clamped,
                         rsp_time_clamped);
                  errors++;
               end
            end
         end
         rsp_ready <= (hold_cycles == 0) && ($urandom_range(99) >= pct);
      end
      quiet_cycles <= (expected_points.size() != 0) ? 0 : quiet_cycles + 1;
   end

   task automatic add_move(longint d, longint a, longint v, longint r);
      gen_move = '{d, a, v, r};
      pending_stim.push_back('{1'b1, CSR_DISTANCE, q_type'(d)});
      pending_stim.push_back('{1'b1, CSR_ACCEL, q_type'(a)});
      pending_stim.push_back('{1'b1, CSR_VELOCITY, q_type'(v)});
      pending_stim.push_back('{1'b1, CSR_DECEL, q_type'(r)});
   endtask

   task automatic add_time(longint t);
      pending_stim.push_back('{1'b0, '0, q_type'(t)});
   endtask

   // a batch of times mostly spread over the move
   task automatic add_times(int count);
      point_type last;
      longint span;
      int pick;
      last = move_position(gen_move, Q_MAX);
      span = (last.clamped && last.tout > 0) ? longint'(last.tout) : (longint'(50) << FB);
      span = span + span / 8;
      if (span > QMAX64) span = QMAX64;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) add_time($urandom_range(0, span));
         else if (pick < 88) add_time(-longint'($urandom_range(0, 1 << 18)));
         else add_time(q_type'($urandom));
      end
   endtask

   function automatic longint pick_rate();
      int k;
      k = $urandom_range(9);
      if (k == 0) return 0;
      if (k == 1) return -longint'($urandom_range(1, 40 << 16));
      return $urandom_range(1, 40 << 16);
   endfunction

   // stimulus and end of test
   initial begin
      longint one;
      one = longint'(1) << FB;
      // unused register index, then reset-valued move
      pending_stim.push_back('{1'b1, 8'hff, q_type'(32'h5a5a_a5a5)});
      add_time(0);
      add_time(one);
      add_time(QMAX64);
      add_time(QMIN64);
      // linear move
      add_move(10 * one, 0, 4 * one, -one);
      add_time(one);
      add_time(2 * one);
      add_time(3 * one);
      add_time(-one);
      // short ramped move: ramps scaled down
      add_move(10 * one, 2 * one, 4 * one, one);
      add_time(0);
      add_time(one / 2);
      add_time(2 * one);
      add_time(3 * one);
      add_time(4 * one);
      add_time(5 * one);
      add_time(100 * one);
      add_time(QMAX64);
      add_time(QMIN64);
      // long move with cruise
      add_move(100 * one, 2 * one, 4 * one, one);
      add_time(one);
      add_time(10 * one);
      add_time(27 * one);
      add_time(30 * one);
      // extreme register settings
      add_move(QMAX64, QMAX64, QMAX64, QMAX64);
      add_times(20);
      add_move(QMIN64, QMIN64, QMIN64, QMIN64);
      add_times(20);
      add_move(QMAX64, 0, QMIN64, 0);
      add_times(20);
      add_move(QMAX64, 1, 1, 0);
      add_times(20);
      add_move(1, 0, 1, QMAX64);
      add_times(20);
      // random moves
      for (int p = 0; p < 14; p++) begin
         case ($urandom_range(5))
            0: add_move(q_type'($urandom), q_type'($urandom), q_type'($urandom),
                        q_type'($urandom));
            1: add_move($urandom_range(1, 200 << 16), -longint'($urandom_range(0, 99)),
                        q_type'($urandom_range(0, 60 << 16)) - (4 << 16), 0);
            default: add_move($urandom_range(1, 200 << 16), pick_rate(),
                              $urandom_range(1, 30 << 16), pick_rate());
         endcase
         add_times(100);
      end
      while (pending_stim.size() != 0 || expected_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("trapezoidal_motion_position regression: pass");
      end else begin
         $display("trapezoidal_motion_position regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4ms;
      $display("trapezoidal_motion_position regression: fail");
      $finish;
   end

endmodule
